// File: rtl/core/radio_device_page_table_assert.svh
// assertion macros shared by the rtl
`ifndef RADIO_DEVICE_PAGE_TABLE_ASSERT_SVH
`define RADIO_DEVICE_PAGE_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RDPT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define RDPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rdpt_pkg.sv
package rdpt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int PAGE_BYTES  = 8;
   localparam int PAGE_W      = PAGE_BYTES * 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int OUT_IDX_W   = 4;
   localparam int OUT_CNT_W   = 5;

   localparam logic [7:0] MAKER_PAGE_NUM   = 8'h50;
   localparam logic [7:0] PRODUCT_PAGE_NUM = 8'h51;
   localparam logic [7:0] EXT_FLAGS_RESET  = 8'd224;

   // request op codes
   localparam logic [1:0] OP_MSG   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [15:0]       id;
      logic [7:0]        rssi;
      logic [PAGE_W-1:0] maker;
      logic [PAGE_W-1:0] product;
   } entry_type;

   typedef struct packed {
      logic    we;
      idx_type waddr;
      idx_type raddr;
   } ram_ctl_type;

   typedef struct packed {
      logic                 updated;
      logic                 new_entry;
      logic                 full_drop;
      logic [OUT_IDX_W-1:0] index;
      logic [OUT_CNT_W-1:0] count;
      logic [7:0]           rssi;
      logic [PAGE_W-1:0]    maker;
      logic [PAGE_W-1:0]    product;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   function automatic logic [OUT_IDX_W-1:0] to_index(idx_type i);
      logic [IDX_W+OUT_IDX_W-1:0] ext;
      ext = {{OUT_IDX_W{1'b0}}, i};
      return ext[OUT_IDX_W-1:0];
   endfunction

   function automatic logic [OUT_CNT_W-1:0] to_count(cnt_type c);
      logic [CNT_W+OUT_CNT_W-1:0] ext;
      ext = {{OUT_CNT_W{1'b0}}, c};
      return ext[OUT_CNT_W-1:0];
   endfunction

endpackage

// File: rtl/core/rdpt_req_if.sv
interface rdpt_req_if
   import rdpt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [15:0]       sender_id;
   logic [7:0]        ext_flags;
   logic [7:0]        rssi_byte;
   logic [PAGE_W-1:0] payload;

   modport source (output valid, op, sender_id, ext_flags, rssi_byte, payload, input ready);
   modport sink (input valid, op, sender_id, ext_flags, rssi_byte, payload, output ready);
endinterface

// File: rtl/core/rdpt_rsp_if.sv
interface rdpt_rsp_if
   import rdpt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 updated;
   logic                 new_entry;
   logic                 full_drop;
   logic [OUT_IDX_W-1:0] entry_index;
   logic [OUT_CNT_W-1:0] entry_count;
   logic [7:0]           entry_rssi;
   logic [PAGE_W-1:0]    entry_maker_page;
   logic [PAGE_W-1:0]    entry_product_page;

   modport source (
      output valid, updated, new_entry, full_drop, entry_index, entry_count,
             entry_rssi, entry_maker_page, entry_product_page,
      input  ready
   );
   modport sink (
      input  valid, updated, new_entry, full_drop, entry_index, entry_count,
             entry_rssi, entry_maker_page, entry_product_page,
      output ready
   );
endinterface

// File: rtl/core/rdpt_csr_if.sv
interface rdpt_csr_if
   import rdpt_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/rdpt_entry_ram.sv
module rdpt_entry_ram
   import rdpt_pkg::*;
(
   input  logic        clock,
   input  ram_ctl_type ctl,
   input  entry_type   wr_data,
   output entry_type   rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= wr_data;
      end
      rd_data_ff <= mem[ctl.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/radio_device_page_table.sv
// channel   modport   moves
// req_ch    sink      request: op, device id, ext flags, rssi byte, 8-byte payload
// rsp_ch    source    one result per request: flags, index, count, entry contents
// csr_ch    sink      write of expected_ext_flags, always ready
//
// a message request with a nonzero id reads the table entries in order, up to 16 of them,
// until a hit, or all entries below the fill count on a miss (at least one); the block takes
// no new request until the result of the last one has been loaded into the output register
// the entry ram (one read port, one write port) gives one read per cycle, which paces the search
// op 0, op 3, id 0 and clear requests skip the search and go straight to their result
// reset clears the fill count but not the entries; entries at or above the count are never used, and
// an appended entry is written whole, so no clearing pass is needed
// the result sits in an output register: a stalled rsp_ch holds the finished request's
// result while the next request is searched; the block waits only to hand over its own
`include "radio_device_page_table_assert.svh"

module radio_device_page_table
   import rdpt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   rdpt_req_if.sink   req_ch,
   rdpt_rsp_if.source rsp_ch,
   rdpt_csr_if.sink   csr_ch
);

   // control state
   state_type state_ff, state_in;
   idx_type   scan_ff, scan_in;
   cnt_type   count_ff, count_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [7:0] flags_ff, flags_in;

   // latched request and results
   logic [15:0]       dev_ff, dev_in;
   logic [7:0]        rssi_ff, rssi_in;
   logic [PAGE_W-1:0] payload_ff, payload_in;
   result_type        pend_ff, pend_in;
   result_type        rsp_ff, rsp_in;

   ram_ctl_type ram_ctl;
   entry_type   wr_entry;
   entry_type   rd_entry;
   logic        req_ready;
   logic        rsp_load;

   rdpt_entry_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   // config register; the user must write it only while idle, the block itself does not enforce this
   assign csr_ch.ready = 1'b1;
   assign flags_in     = csr_ch.valid ? csr_ch.data : flags_ff;

   always_comb begin
      cnt_type   scan_cnt;
      cnt_type   next_cnt;
      logic      hit;
      logic      more;
      logic      is_maker;
      logic      is_product;
      entry_type mod_entry;
      entry_type add_entry;

      state_in   = state_ff;
      scan_in    = scan_ff;
      count_in   = count_ff;
      dev_in     = dev_ff;
      rssi_in    = rssi_ff;
      payload_in = payload_ff;
      pend_in    = pend_ff;
      ram_ctl    = '0;
      req_ready  = 1'b0;
      rsp_load   = 1'b0;

      // compare of the entry read last cycle
      scan_cnt = cnt_type'(scan_ff);
      next_cnt = cnt_type'(scan_cnt + 1'b1);
      hit      = (scan_cnt < count_ff) && (rd_entry.id == dev_ff);
      more     = next_cnt < count_ff;

      is_maker   = payload_ff[7:0] == MAKER_PAGE_NUM;
      is_product = payload_ff[7:0] == PRODUCT_PAGE_NUM;

      // hit: modify the entry read back
      mod_entry      = rd_entry;
      mod_entry.rssi = rssi_ff;
      if (is_maker) begin
         mod_entry.maker = payload_ff;
      end
      if (is_product) begin
         mod_entry.product = payload_ff;
      end

      // miss: fresh entry, slots not hit by this page start at zero
      add_entry.id      = dev_ff;
      add_entry.rssi    = rssi_ff;
      add_entry.maker   = is_maker ? payload_ff : '0;
      add_entry.product = is_product ? payload_ff : '0;

      wr_entry = mod_entry;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            scan_in   = '0;
            if (req_ch.valid) begin
               dev_in        = req_ch.sender_id;
               rssi_in       = (req_ch.ext_flags == flags_ff) ? req_ch.rssi_byte : 8'd0;
               payload_in    = req_ch.payload;
               pend_in       = '0;
               pend_in.count = to_count(count_ff);
               if (req_ch.op == OP_CLEAR) begin
                  count_in      = '0;
                  pend_in.count = '0;
                  state_in      = ST_DONE;
               end else if (req_ch.op == OP_MSG && req_ch.sender_id != 16'd0) begin
                  // entry 0 is read now, compared next cycle
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SEARCH: begin
            priority if (hit) begin
               ram_ctl.we        = 1'b1;
               ram_ctl.waddr     = scan_ff;
               wr_entry          = mod_entry;
               pend_in.updated   = is_maker | is_product;
               pend_in.new_entry = 1'b0;
               pend_in.full_drop = 1'b0;
               pend_in.index     = to_index(scan_ff);
               pend_in.count     = to_count(count_ff);
               pend_in.rssi      = mod_entry.rssi;
               pend_in.maker     = mod_entry.maker;
               pend_in.product   = mod_entry.product;
               state_in          = ST_DONE;
            end else if (more) begin
               scan_in       = idx_type'(next_cnt);
               ram_ctl.raddr = idx_type'(next_cnt);
            end else if (count_ff < cnt_type'(TABLE_DEPTH)) begin
               // append at the fill count
               ram_ctl.we        = 1'b1;
               ram_ctl.waddr     = idx_type'(count_ff);
               wr_entry          = add_entry;
               count_in          = cnt_type'(count_ff + 1'b1);
               pend_in.updated   = 1'b1;
               pend_in.new_entry = 1'b1;
               pend_in.full_drop = 1'b0;
               pend_in.index     = to_index(idx_type'(count_ff));
               pend_in.count     = to_count(count_in);
               pend_in.rssi      = add_entry.rssi;
               pend_in.maker     = add_entry.maker;
               pend_in.product   = add_entry.product;
               state_in          = ST_DONE;
            end else begin
               // table full, unknown device dropped
               pend_in           = '0;
               pend_in.full_drop = 1'b1;
               pend_in.count     = to_count(count_ff);
               state_in          = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   // output register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);
   assign rsp_in       = rsp_load ? pend_ff : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= EXT_FLAGS_RESET;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff     <= dev_in;
      rssi_ff    <= rssi_in;
      payload_ff <= payload_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.updated            = rsp_ff.updated;
   assign rsp_ch.new_entry          = rsp_ff.new_entry;
   assign rsp_ch.full_drop          = rsp_ff.full_drop;
   assign rsp_ch.entry_index        = rsp_ff.index;
   assign rsp_ch.entry_count        = rsp_ff.count;
   assign rsp_ch.entry_rssi         = rsp_ff.rssi;
   assign rsp_ch.entry_maker_page   = rsp_ff.maker;
   assign rsp_ch.entry_product_page = rsp_ff.product;

   // ram is written only as a search finishes
   `RDPT_ASSERT_NOW(a_write_in_search, ram_ctl.we, state_ff == ST_SEARCH, "ram write outside search")
   // fill count never passes the depth
   `RDPT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= cnt_type'(TABLE_DEPTH), "fill count overflow")
   // a dropped request leaves the table alone
   `RDPT_ASSERT_NOW(a_drop_no_write, state_ff == ST_SEARCH && pend_in.full_drop, !ram_ctl.we, "write on drop")
   // an append bumps the count by one
   `RDPT_ASSERT_NEXT(a_append_count, state_ff == ST_SEARCH && ram_ctl.we && pend_in.new_entry, count_ff == cnt_type'($past(count_ff) + 1'b1), "append count slip")
   // a new entry is always reported as an update
   `RDPT_ASSERT_NOW(a_new_is_update, rsp_valid_ff && rsp_ff.new_entry, rsp_ff.updated && !rsp_ff.full_drop, "new entry flags")

endmodule
